>>> hdl/bfpr_pkg.sv
`default_nettype none

package bfpr_pkg;

	// Length of the target schedule before it wraps (1 to 8)
	localparam int SCHED_STEPS = 6;

	// Item kinds carried in tuser
	localparam logic [1:0] CMD_SAMPLE = 2'd0;
	localparam logic [1:0] CMD_CTRL   = 2'd1;
	localparam logic [1:0] CMD_STEP   = 2'd2;
	localparam logic [1:0] CMD_NONE   = 2'd3;

	// Register indexes (byte address is 4 * index)
	localparam logic [2:0] REG_PROP_GAIN  = 3'd0;
	localparam logic [2:0] REG_INTEG_GAIN = 3'd1;
	localparam logic [2:0] REG_DERIV_GAIN = 3'd2;
	localparam logic [2:0] REG_INTEG_LIM  = 3'd3;
	localparam logic [2:0] REG_OUT_LIM    = 3'd4;
	localparam logic [2:0] REG_ADC_SCALE  = 3'd5;
	localparam logic [2:0] REG_MIN_FREQ   = 3'd6;
	localparam logic [2:0] REG_DEADBAND   = 3'd7;

	// Register reset values
	localparam logic [23:0] PROP_GAIN_RST  = 24'd229376;
	localparam logic [23:0] INTEG_GAIN_RST = 24'd131;
	localparam logic [23:0] DERIV_GAIN_RST = 24'd1310720;
	localparam logic [15:0] INTEG_LIM_RST  = 16'd12800;
	localparam logic [15:0] OUT_LIM_RST    = 16'd35840;
	localparam logic [15:0] ADC_SCALE_RST  = 16'd1704;
	localparam logic [15:0] MIN_FREQ_RST   = 16'd100;
	localparam logic [15:0] DEADBAND_RST   = 16'd51;

	// State reset values
	localparam logic [15:0] FREQ_RST   = 16'd100;
	localparam logic [7:0]  TARGET_RST = 8'd20;

	// Error magnitude (Q8.8) above which the PID output gets the 2.5x boost
	localparam logic signed [17:0] BOOST_ERR = 18'sd5120;

	typedef struct packed {
		logic [23:0] prop_gain;
		logic [23:0] integ_gain;
		logic [23:0] deriv_gain;
		logic [15:0] integral_limit;
		logic [15:0] output_limit;
		logic [15:0] adc_scale;
		logic [15:0] min_freq;
		logic [15:0] deadband;
	} cfg_t;

	typedef struct packed {
		logic [15:0] freq_hz;
		logic        freq_changed;
		logic [15:0] volts_q8;
		logic [7:0]  target_volts;
		logic        on_target;
		logic [2:0]  step_index;
	} res_t;

	typedef struct packed {
		logic signed [17:0] err;
		logic signed [24:0] integ;
		logic [15:0]        freq;
		logic               freq_wr;
	} pid_res_t;

	// Target voltage schedule in whole volts; slots past the sixth hold 20 V
	function automatic logic [7:0] sched_volts(input logic [2:0] pos);
		logic [7:0] v;
		case (pos)
			3'd0:    v = 8'd20;
			3'd1:    v = 8'd50;
			3'd2:    v = 8'd90;
			3'd3:    v = 8'd100;
			3'd4:    v = 8'd90;
			3'd5:    v = 8'd50;
			default: v = 8'd20;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

>>> hdl/bfpr_regs.sv
`default_nettype none

module bfpr_regs
	import bfpr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	output cfg_t             cfg
);

	logic       wr_en;
	logic [2:0] idx;
	cfg_t       cfg_q;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign idx    = paddr[4:2];
	assign cfg    = cfg_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain      <= PROP_GAIN_RST;
			cfg_q.integ_gain     <= INTEG_GAIN_RST;
			cfg_q.deriv_gain     <= DERIV_GAIN_RST;
			cfg_q.integral_limit <= INTEG_LIM_RST;
			cfg_q.output_limit   <= OUT_LIM_RST;
			cfg_q.adc_scale      <= ADC_SCALE_RST;
			cfg_q.min_freq       <= MIN_FREQ_RST;
			cfg_q.deadband       <= DEADBAND_RST;
		end else if (wr_en) begin
			case (idx)
				REG_PROP_GAIN:  cfg_q.prop_gain      <= pwdata[23:0];
				REG_INTEG_GAIN: cfg_q.integ_gain     <= pwdata[23:0];
				REG_DERIV_GAIN: cfg_q.deriv_gain     <= pwdata[23:0];
				REG_INTEG_LIM:  cfg_q.integral_limit <= pwdata[15:0];
				REG_OUT_LIM:    cfg_q.output_limit   <= pwdata[15:0];
				REG_ADC_SCALE:  cfg_q.adc_scale      <= pwdata[15:0];
				REG_MIN_FREQ:   cfg_q.min_freq       <= pwdata[15:0];
				REG_DEADBAND:   cfg_q.deadband       <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		case (idx)
			REG_PROP_GAIN:  prdata = {8'h00, cfg_q.prop_gain};
			REG_INTEG_GAIN: prdata = {8'h00, cfg_q.integ_gain};
			REG_DERIV_GAIN: prdata = {8'h00, cfg_q.deriv_gain};
			REG_INTEG_LIM:  prdata = {16'h0000, cfg_q.integral_limit};
			REG_OUT_LIM:    prdata = {16'h0000, cfg_q.output_limit};
			REG_ADC_SCALE:  prdata = {16'h0000, cfg_q.adc_scale};
			REG_MIN_FREQ:   prdata = {16'h0000, cfg_q.min_freq};
			REG_DEADBAND:   prdata = {16'h0000, cfg_q.deadband};
			default:        prdata = 32'h0000_0000;
		endcase
	end

endmodule

`default_nettype wire

>>> hdl/bfpr_pid.sv
`default_nettype none

module bfpr_pid
	import bfpr_pkg::*;
(
	input  wire logic [15:0]        freq,
	input  wire logic [15:0]        volts,
	input  wire logic [7:0]         target,
	input  wire logic signed [17:0] err_prev,
	input  wire logic signed [24:0] integ_acc,
	input  wire cfg_t               cfg,
	output pid_res_t                pid
);

	logic signed [17:0] err_new;
	logic signed [18:0] derr;
	logic signed [24:0] kp_s, ki_s, kd_s;
	logic signed [42:0] p_prod, i_prod;
	logic signed [43:0] d_prod;
	logic signed [44:0] pd_sum;
	logic signed [36:0] pd_sh;
	logic signed [34:0] i_inc;
	logic signed [35:0] i_sum, ilim, ilim_neg, i_clamp;
	logic signed [24:0] integ_new;
	logic signed [37:0] o_sum, olim, olim_neg, o_clamp;
	logic signed [24:0] o_val;
	logic signed [27:0] o_x, scaled;
	logic               boost;
	logic signed [34:0] f_sum;
	logic signed [17:0] nf;

	// Error, Q8.8
	assign err_new = $signed({2'b00, target, 8'h00}) - $signed({2'b00, volts});
	assign derr    = {err_new[17], err_new} - {err_prev[17], err_prev};

	// Gain products (gains are unsigned Q8.16)
	assign kp_s   = $signed({1'b0, cfg.prop_gain});
	assign ki_s   = $signed({1'b0, cfg.integ_gain});
	assign kd_s   = $signed({1'b0, cfg.deriv_gain});
	assign p_prod = err_new * kp_s;
	assign i_prod = err_new * ki_s;
	assign d_prod = derr * kd_s;

	// Integral update with symmetric clamp, Q.16
	assign i_inc    = i_prod[42:8];
	assign i_sum    = integ_acc + i_inc;
	assign ilim     = $signed({12'h000, cfg.integral_limit, 8'h00});
	assign ilim_neg = -ilim;
	always_comb begin
		if (i_sum > ilim)
			i_clamp = ilim;
		else if (i_sum < ilim_neg)
			i_clamp = ilim_neg;
		else
			i_clamp = i_sum;
	end
	assign integ_new = i_clamp[24:0];

	// PID output with symmetric clamp, Q.16
	assign pd_sum   = p_prod + d_prod;
	assign pd_sh    = pd_sum[44:8];
	assign o_sum    = pd_sh + integ_new;
	assign olim     = $signed({14'h0000, cfg.output_limit, 8'h00});
	assign olim_neg = -olim;
	always_comb begin
		if (o_sum > olim)
			o_clamp = olim;
		else if (o_sum < olim_neg)
			o_clamp = olim_neg;
		else
			o_clamp = o_sum;
	end
	assign o_val = o_clamp[24:0];

	// Scale to Q.17: x2 normally, x5 (2.5 in Q.17) on large error
	assign boost  = (err_new > BOOST_ERR) || (err_new < -BOOST_ERR);
	assign o_x    = 28'(o_val);
	assign scaled = boost ? ((o_x <<< 2) + o_x) : (o_x <<< 1);

	// New frequency, floored and saturated
	assign f_sum = $signed({2'b00, freq, 17'h00000}) + scaled;
	assign nf    = f_sum[34:17];

	assign pid.err     = err_new;
	assign pid.integ   = integ_new;
	assign pid.freq_wr = nf >= $signed({2'b00, cfg.min_freq});
	assign pid.freq    = (nf > $signed(18'h0ffff)) ? 16'hffff : nf[15:0];

endmodule

`default_nettype wire

>>> hdl/bfpr_core.sv
`default_nettype none

module bfpr_core
	import bfpr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        upd,
	input  wire logic [1:0]  cmd,
	input  wire logic [11:0] adc_raw,
	input  wire cfg_t        cfg,
	output res_t             res
);

	logic [15:0]        freq_q, volts_q;
	logic               near_q;
	logic signed [17:0] err_q;
	logic signed [24:0] integ_q;
	logic [2:0]         sched_q;
	logic [7:0]         target_q;

	logic [15:0]        freq_d, volts_d;
	logic               near_d, changed_d;
	logic signed [17:0] err_d;
	logic signed [24:0] integ_d;
	logic [2:0]         sched_d;
	logic [7:0]         target_d;

	logic [27:0]        adc_prod;
	logic [15:0]        volts_new;
	logic signed [17:0] diff;
	logic [17:0]        mag;
	logic               far;
	logic               skip;
	logic [3:0]         sched_inc;
	pid_res_t           pid;

	// Sample path: raw count to Q8.8 volts, saturated
	assign adc_prod  = adc_raw * cfg.adc_scale;
	assign volts_new = (|adc_prod[27:24]) ? 16'hffff : adc_prod[23:8];
	assign diff      = $signed({2'b00, volts_new}) - $signed({2'b00, target_q, 8'h00});
	assign mag       = diff[17] ? 18'(-diff) : diff;
	assign far       = mag >= {2'b00, cfg.deadband};

	// Control tick is skipped below the minimum or when on target
	assign skip = (freq_q < cfg.min_freq) || near_q;

	assign sched_inc = {1'b0, sched_q} + 4'd1;

	bfpr_pid u_pid (
		.freq      (freq_q),
		.volts     (volts_q),
		.target    (target_q),
		.err_prev  (err_q),
		.integ_acc (integ_q),
		.cfg       (cfg),
		.pid       (pid)
	);

	// Next state per item kind
	always_comb begin
		freq_d    = freq_q;
		volts_d   = volts_q;
		near_d    = near_q;
		err_d     = err_q;
		integ_d   = integ_q;
		sched_d   = sched_q;
		target_d  = target_q;
		changed_d = 1'b0;
		case (cmd)
			CMD_SAMPLE: begin
				volts_d = volts_new;
				near_d  = !far;
				if (far && !diff[17] && (diff != 18'sd0)) begin
					if ({1'b0, freq_q} >= ({1'b0, cfg.min_freq} + 17'd2))
						freq_d = freq_q - 16'd2;
				end else if (far && diff[17]) begin
					freq_d = (freq_q > 16'hfffd) ? 16'hffff : freq_q + 16'd2;
				end
			end
			CMD_CTRL: begin
				if (!skip) begin
					err_d   = pid.err;
					integ_d = pid.integ;
					if (pid.freq_wr) begin
						freq_d    = pid.freq;
						changed_d = 1'b1;
					end
				end
			end
			CMD_STEP: begin
				sched_d  = (sched_inc >= 4'(SCHED_STEPS)) ? 3'd0 : sched_inc[2:0];
				target_d = sched_volts(sched_d);
			end
			default: ;
		endcase
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q   <= FREQ_RST;
			volts_q  <= 16'h0000;
			near_q   <= 1'b0;
			err_q    <= 18'sd0;
			integ_q  <= 25'sd0;
			sched_q  <= 3'd0;
			target_q <= TARGET_RST;
		end else if (upd) begin
			freq_q   <= freq_d;
			volts_q  <= volts_d;
			near_q   <= near_d;
			err_q    <= err_d;
			integ_q  <= integ_d;
			sched_q  <= sched_d;
			target_q <= target_d;
		end
	end

	assign res.freq_hz      = freq_d;
	assign res.freq_changed = changed_d;
	assign res.volts_q8     = volts_d;
	assign res.target_volts = target_d;
	assign res.on_target    = near_d;
	assign res.step_index   = sched_d;

	// Only sample items touch the measured voltage
	a_volts_only_sample: assert property (@(posedge clk) disable iff (!arst_n)
		upd && (cmd != CMD_SAMPLE) |=> $stable(volts_q))
		else $error("voltage changed on a non-sample item");

	// Step and unused items leave the frequency alone
	a_freq_hold: assert property (@(posedge clk) disable iff (!arst_n)
		upd && ((cmd == CMD_STEP) || (cmd == CMD_NONE)) |=> $stable(freq_q))
		else $error("frequency changed on a step or unused item");

	// Schedule position stays inside the schedule
	a_sched_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, sched_q} < 4'(SCHED_STEPS))
		else $error("schedule position out of range");

endmodule

`default_nettype wire

>>> hdl/boost_frequency_pid_regulator_unit.sv
`default_nettype none

// Channel   Dir  Handshake         Payload
// s_*       in   s_tvalid/tready   s_tuser: cmd; s_tdata: adc_raw
// m_*       out  m_tvalid/tready   m_tdata: freq_hz, freq_changed, volts_q8,
//                                  target_volts, on_target, step_index
// APB       in   psel/penable      eight registers at byte address 4*index
//
// One request per clock while m_* is not stalled; an accepted request goes to
// the input register, then to the result register, which loads as the state
// registers update.
// The state registers and the single-pass PID datapath between them set the
// rate: each item sees the state left by the one before it.
// arst_n clears the state, the registers and both valid flags at once.
// A stalled result holds in the output register; the input register keeps
// taking requests until it also holds one.

module boost_frequency_pid_regulator_unit
	import bfpr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [11:0] adc_raw, rest zero
	input  wire logic [1:0]  s_tuser,   // [1:0] cmd
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,   // [15:0] freq_hz, [16] freq_changed,
	                                    // [32:17] volts_q8, [40:33] target_volts,
	                                    // [41] on_target, [44:42] step_index
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	cfg_t        cfg;
	logic        s1_valid;
	logic [1:0]  cmd_s1;
	logic [11:0] adc_s1;
	logic        out_valid_q;
	res_t        res_q;
	res_t        res;
	logic        advance;
	logic        upd;

	bfpr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Handshake: result register frees when empty or taken
	assign advance  = !out_valid_q || m_tready;
	assign upd      = s1_valid && advance;
	assign s_tready = !s1_valid || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (s_tready) begin
			s1_valid <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1 <= s_tuser;
			adc_s1 <= s_tdata[11:0];
		end
	end

	bfpr_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.upd     (upd),
		.cmd     (cmd_s1),
		.adc_raw (adc_s1),
		.cfg     (cfg),
		.res     (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, res_q.step_index, res_q.on_target, res_q.target_volts,
		res_q.volts_q8, res_q.freq_changed, res_q.freq_hz};

	// A held input with a stalled result blocks new requests
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && out_valid_q && !m_tready |-> !s_tready)
		else $error("request taken while both stages are full");

	// An accepted request lands in the input register
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> s1_valid)
		else $error("accepted request lost");

	// Every processed item produces a result
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		upd |=> out_valid_q)
		else $error("processed item left no result");

endmodule

`default_nettype wire
